### sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, types and helpers for the LFU replacement core with
// LRU tie-break: geometry, operation codes, store entry and port structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // cache geometry
    localparam int SETS    = 64;
    localparam int WAYS    = 16;
    localparam int BLOCKS  = SETS * WAYS;
    localparam int ADDR_W  = $clog2(BLOCKS);
    localparam int WAY_IW  = $clog2(WAYS);

    // item field widths
    localparam int OP_W    = 2;
    localparam int SET_W   = 6;
    localparam int WAY_W   = 4;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL   = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // one block of replacement state
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    // compare unit feed control
    typedef struct packed {
        logic              valid;
        logic              first;
        logic [WAY_IW-1:0] way;
    } sel_feed_t;

    // flat block address of a (set, way) pair
    function automatic logic [ADDR_W-1:0] blk_addr(input logic [SET_W-1:0] set_idx,
                                                   input logic [WAY_IW-1:0] way_idx);
        logic [31:0] full;
        full = 32'(set_idx) * 32'(WAYS) + 32'(way_idx);
        return ADDR_W'(full);
    endfunction

endpackage

### sv/lfu_if.sv
// ----------------------------------------------------------------------------
// lfu_if
// Valid/ready channels of the replacement core: event items in, victim
// items out.
// ----------------------------------------------------------------------------
interface lfu_req_if;
    logic                       valid;
    logic                       ready;
    logic [lfu_pkg::OP_W-1:0]   opcode;
    logic [lfu_pkg::SET_W-1:0]  set_index;
    logic [lfu_pkg::WAY_W-1:0]  way_index;
    logic                       is_write;
    logic                       was_hit;

    modport source (output valid, output opcode, output set_index, output way_index,
                    output is_write, output was_hit, input ready);
    modport sink   (input valid, input opcode, input set_index, input way_index,
                    input is_write, input was_hit, output ready);
endinterface

interface lfu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [lfu_pkg::WAY_W-1:0]  evict_way;

    modport source (output valid, output evict_way, input ready);
    modport sink   (input valid, input evict_way, output ready);
endinterface

### sv/lfu_store.sv
// ----------------------------------------------------------------------------
// lfu_store
// Block state memory: count and stamp per block, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module lfu_store
(
    input  logic                        clk,
    input  lfu_pkg::mem_wr_t            wr,
    input  logic                        rd_en,
    input  logic [lfu_pkg::ADDR_W-1:0]  rd_addr,
    output lfu_pkg::entry_t             rd_data
);

    lfu_pkg::entry_t mem [lfu_pkg::BLOCKS];
    lfu_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/lfu_sel.sv
// ----------------------------------------------------------------------------
// lfu_sel
// Shared compare unit: folds one way per cycle into the running best,
// least count first, then oldest stamp, lowest way on a full tie.
// ----------------------------------------------------------------------------
module lfu_sel
(
    input  logic                        clk,
    input  lfu_pkg::sel_feed_t          feed,
    input  lfu_pkg::entry_t             cand,
    output logic [lfu_pkg::WAY_IW-1:0]  best_way
);

    logic [lfu_pkg::COUNT_W-1:0] best_count_reg;
    logic [lfu_pkg::STAMP_W-1:0] best_stamp_reg;
    logic [lfu_pkg::WAY_IW-1:0]  best_way_reg;
    logic                        take;

    // strictly better, or the first way of the scan
    assign take = feed.first
               || (cand.count < best_count_reg)
               || ((cand.count == best_count_reg) && (cand.stamp < best_stamp_reg));

    always_ff @(posedge clk)
    begin
        if (feed.valid && take)
        begin
            best_count_reg <= cand.count;
            best_stamp_reg <= cand.stamp;
            best_way_reg   <= feed.way;
        end
    end

    assign best_way = best_way_reg;

endmodule

### sv/lfu_replacement_lru_tiebreak_core.sv
// ----------------------------------------------------------------------------
// lfu_replacement_lru_tiebreak_core
// LFU replacement policy with LRU tie-break for a set-associative cache.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event item: victim query, fill of a way or access update.
//   rsp carries one evict_way item for each victim query; fills, updates
//   and unused opcodes give no item.
//   A victim query reads the set's WAYS blocks one per cycle through the
//   single read port of the state memory into a shared compare unit; after
//   the scan, a drain step and a final step, the result appears and
//   req.ready returns.
//   A query to a set out of range skips the scan and answers way 0.
//   A fill writes its block directly; an access update that is an in-range
//   read hit reads, modifies and writes its block.
//   req.ready is low while an item is in work.
//   After reset a clearing pass writes zero into every block, one block a
//   cycle, SETS * WAYS (1024) blocks in all; no item is accepted meanwhile.
//   rsp is held in an output register; a stalled receiver holds the next
//   query only at its final step, while the core still takes new items as
//   long as no second result is pending.
// ----------------------------------------------------------------------------
module lfu_replacement_lru_tiebreak_core
(
    input  logic         clk,
    input  logic         rst_n,
    lfu_req_if.sink      req,
    lfu_rsp_if.source    rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_UPD,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                         state_reg;
    logic [lfu_pkg::ADDR_W-1:0]     clr_addr_reg;
    logic [lfu_pkg::WAY_IW-1:0]     wayc_reg;
    logic                           pend_reg;
    logic [lfu_pkg::WAY_IW-1:0]     pend_way_reg;
    logic                           oor_reg;
    logic [lfu_pkg::STAMP_W-1:0]    evt_reg;
    logic                           out_valid_reg;
    logic [lfu_pkg::WAY_W-1:0]      out_way_reg;

    logic [lfu_pkg::OP_W-1:0]       op_reg;
    logic [lfu_pkg::SET_W-1:0]      set_reg;
    logic [lfu_pkg::WAY_W-1:0]      way_reg;
    logic                           write_reg;
    logic                           hit_reg;

    lfu_pkg::mem_wr_t               wr;
    logic                           rd_en;
    logic [lfu_pkg::ADDR_W-1:0]     rd_addr;
    lfu_pkg::entry_t                rd_data;
    lfu_pkg::sel_feed_t             feed;
    logic [lfu_pkg::WAY_IW-1:0]     best_way;

    logic                           req_set_ok;
    logic                           in_range;
    logic [lfu_pkg::ADDR_W-1:0]     blk_reg_addr;
    logic                           out_free;
    logic [lfu_pkg::WAY_W-1:0]      result_way;

    // range checks and address of the registered item
    assign req_set_ok   = 32'(req.set_index) < 32'(lfu_pkg::SETS);
    assign in_range     = (32'(set_reg) < 32'(lfu_pkg::SETS))
                       && (32'(way_reg) < 32'(lfu_pkg::WAYS));
    assign blk_reg_addr = lfu_pkg::blk_addr(set_reg, lfu_pkg::WAY_IW'(way_reg));
    assign out_free     = !out_valid_reg || rsp.ready;
    assign result_way   = oor_reg ? '0 : lfu_pkg::WAY_W'(best_way);

    // memory ports and compare feed
    always_comb
    begin
        wr      = '0;
        rd_en   = 1'b0;
        rd_addr = blk_reg_addr;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en   = 1'b1;
                wr.addr = clr_addr_reg;
            end
            S_EXEC:
            begin
                if (in_range && (op_reg == lfu_pkg::OP_FILL))
                begin
                    wr.en         = 1'b1;
                    wr.addr       = blk_reg_addr;
                    wr.data.count = lfu_pkg::COUNT_W'(1);
                    wr.data.stamp = evt_reg;
                end
                rd_en = in_range && (op_reg == lfu_pkg::OP_UPDATE) && hit_reg && !write_reg;
            end
            S_UPD:
            begin
                wr.en         = 1'b1;
                wr.addr       = blk_reg_addr;
                wr.data.count = (rd_data.count == lfu_pkg::COUNT_MAX)
                              ? rd_data.count : rd_data.count + 1'b1;
                wr.data.stamp = evt_reg;
            end
            S_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = lfu_pkg::blk_addr(set_reg, wayc_reg);
            end
            default:
            begin
            end
        endcase
        feed.valid = pend_reg;
        feed.first = (pend_way_reg == '0);
        feed.way   = pend_way_reg;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.evict_way = out_way_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            wayc_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_way_reg  <= '0;
            oor_reg       <= 1'b0;
            evt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_way_reg   <= '0;
            op_reg        <= '0;
            set_reg       <= '0;
            way_reg       <= '0;
            write_reg     <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            // scan pipeline: read data arrives in the cycle after the address
            pend_reg     <= (state_reg == S_SCAN);
            pend_way_reg <= wayc_reg;

            // output register: load at the final step of a query, clear once taken
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_way_reg   <= result_way;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (wr.en && (state_reg != S_CLEAR))
            begin
                evt_reg <= evt_reg + 1'b1;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (32'(clr_addr_reg) == 32'(lfu_pkg::BLOCKS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.opcode;
                        set_reg   <= req.set_index;
                        way_reg   <= req.way_index;
                        write_reg <= req.is_write;
                        hit_reg   <= req.was_hit;
                        wayc_reg  <= '0;
                        oor_reg   <= !req_set_ok;
                        if (req.opcode == lfu_pkg::OP_QUERY)
                        begin
                            state_reg <= req_set_ok ? S_SCAN : S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    state_reg <= rd_en ? S_UPD : S_IDLE;
                end
                S_UPD:
                begin
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    wayc_reg <= wayc_reg + 1'b1;
                    if (32'(wayc_reg) == 32'(lfu_pkg::WAYS - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // state memory
    lfu_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared compare unit
    lfu_sel u_sel
    (
        .clk      (clk),
        .feed     (feed),
        .cand     (rd_data),
        .best_way (best_way)
    );

    // checks
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("item accepted during clearing pass");

    a_evt_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (evt_reg == $past(evt_reg)) || (evt_reg == $past(evt_reg) + 64'd1))
        else $error("event counter moved by more than one");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_DRAIN) |-> !wr.en)
        else $error("state memory written during victim scan");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("victim item raised outside the final step of a query");

endmodule

### test/lfu_victim_checker.sv
// ----------------------------------------------------------------------------
// lfu_victim_checker
// Watches the event and victim channels of the LFU replacement core, keeps
// its own copy of the per-block use counts and last-use stamps, works out the
// victim way for every accepted query and compares it with the returned item.
// ----------------------------------------------------------------------------
module lfu_victim_checker
(
    input  logic clk,
    input  logic rst_n,
    lfu_req_if   req,
    lfu_rsp_if   rsp,
    output int   errors,
    output int   victims_due
);

    // one outstanding victim, with its set for the report
    typedef struct {
        logic [lfu_pkg::SET_W-1:0] set_index;
        logic [lfu_pkg::WAY_W-1:0] evict_way;
    } victim_exp_t;

    logic [lfu_pkg::COUNT_W-1:0] use_cnt   [lfu_pkg::BLOCKS];
    logic [lfu_pkg::STAMP_W-1:0] use_stamp [lfu_pkg::BLOCKS];
    logic [lfu_pkg::STAMP_W-1:0] event_no;
    victim_exp_t                 victim_q  [$];
    victim_exp_t                 oldest;
    int                          blk;
    bit                          in_range;

    // least count wins, then the oldest stamp, then the lowest way
    function automatic logic [lfu_pkg::WAY_W-1:0] least_used_way(
        input logic [lfu_pkg::SET_W-1:0] set_i);
        int                          base;
        int                          best;
        logic [lfu_pkg::COUNT_W-1:0] best_cnt;
        logic [lfu_pkg::STAMP_W-1:0] best_stamp;
        if (int'(set_i) >= lfu_pkg::SETS)
            return '0;
        base       = int'(set_i) * lfu_pkg::WAYS;
        best       = 0;
        best_cnt   = use_cnt[base];
        best_stamp = use_stamp[base];
        for (int w = 1; w < lfu_pkg::WAYS; w++)
        begin
            if (use_cnt[base + w] < best_cnt ||
                (use_cnt[base + w] == best_cnt && use_stamp[base + w] < best_stamp))
            begin
                best       = w;
                best_cnt   = use_cnt[base + w];
                best_stamp = use_stamp[base + w];
            end
        end
        return lfu_pkg::WAY_W'(best);
    endfunction

    task automatic log_failure(input string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lfu_pkg::BLOCKS; i++)
            begin
                use_cnt[i]   = '0;
                use_stamp[i] = '0;
            end
            event_no = '0;
            victim_q.delete();
            errors      = 0;
            victims_due = 0;
        end
        else
        begin
            // returned victim against the oldest outstanding query
            if (rsp.valid && rsp.ready)
            begin
                if (victim_q.size() == 0)
                    log_failure($sformatf("victim item way %0d with no query outstanding",
                                          rsp.evict_way));
                else
                begin
                    oldest = victim_q.pop_front();
                    if (rsp.evict_way !== oldest.evict_way)
                        log_failure($sformatf("evict_way for set %0d: expected %0d, got %0d",
                                              oldest.set_index, oldest.evict_way,
                                              rsp.evict_way));
                end
            end

            // accepted event item updates the shadow state
            if (req.valid && req.ready)
            begin
                blk      = int'(req.set_index) * lfu_pkg::WAYS + int'(req.way_index);
                in_range = int'(req.set_index) < lfu_pkg::SETS
                        && int'(req.way_index) < lfu_pkg::WAYS;
                case (req.opcode)
                    lfu_pkg::OP_QUERY:
                    begin
                        oldest.set_index = req.set_index;
                        oldest.evict_way = least_used_way(req.set_index);
                        victim_q.push_back(oldest);
                    end
                    lfu_pkg::OP_FILL:
                    begin
                        if (in_range)
                        begin
                            use_cnt[blk]   = lfu_pkg::COUNT_W'(1);
                            use_stamp[blk] = event_no;
                            event_no       = event_no + 1'b1;
                        end
                    end
                    lfu_pkg::OP_UPDATE:
                    begin
                        // only a read hit counts as a use; count sticks at its maximum
                        if (in_range && req.was_hit && !req.is_write)
                        begin
                            if (use_cnt[blk] != lfu_pkg::COUNT_MAX)
                                use_cnt[blk] = use_cnt[blk] + 1'b1;
                            use_stamp[blk] = event_no;
                            event_no       = event_no + 1'b1;
                        end
                    end
                    default:
                    begin
                        // unused opcode leaves everything alone
                    end
                endcase
            end
            victims_due = victim_q.size();
        end
    end

endmodule

### test/lfu_replacement_lru_tiebreak_core_tb.sv
// ----------------------------------------------------------------------------
// lfu_replacement_lru_tiebreak_core_tb
// Drives event items into the LFU replacement core: a short directed run of
// fills, hits, ignored accesses and queries, then random sequences that fill
// whole sets and hammer them with hits and queries, mixed with noise items.
// Both channels idle in random bursts; a checker beside the core predicts
// every victim and reports mismatches.
// ----------------------------------------------------------------------------
module lfu_replacement_lru_tiebreak_core_tb;

    localparam int                       N_EVENTS       = 1500;
    localparam int                       QUIET_TAIL     = 150;
    localparam int                       DRAIN_EVERY    = 300;
    localparam int                       WATCHDOG_LIMIT = 5000;
    localparam int                       SETTLE_CYCLES  = 2 * (lfu_pkg::WAYS + 3);
    localparam logic [lfu_pkg::OP_W-1:0] OP_UNUSED      = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   events_sent;
    int   idle_pct;
    bit   quiet;
    int   errors;
    int   victims_due;
    int   stalled;

    lfu_req_if req_ch ();
    lfu_rsp_if rsp_ch ();

    always #2 clk = ~clk;

    lfu_replacement_lru_tiebreak_core u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lfu_victim_checker u_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (errors),
        .victims_due (victims_due)
    );

    // one event item, held until accepted, then an optional idle burst
    task automatic put_event(input logic [lfu_pkg::OP_W-1:0]  op,
                             input logic [lfu_pkg::SET_W-1:0] set_i,
                             input logic [lfu_pkg::WAY_W-1:0] way_i,
                             input logic wr, input logic hit);
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.set_index <= set_i;
        req_ch.way_index <= way_i;
        req_ch.is_write  <= wr;
        req_ch.was_hit   <= hit;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        events_sent++;
        if (events_sent >= N_EVENTS - QUIET_TAIL)
            quiet = 1'b1;
        if (!quiet && $urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clk);
        end
    endtask

    // hold off until every victim has come back
    task automatic drain_victims();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (victims_due != 0);
        @(posedge clk);
    endtask

    // a few sets take most of the traffic so that their state builds up
    function automatic logic [lfu_pkg::SET_W-1:0] pick_set();
        case ($urandom_range(3))
            0:       return lfu_pkg::SET_W'(0);
            1:       return lfu_pkg::SET_W'(lfu_pkg::SETS - 1);
            2:       return lfu_pkg::SET_W'($urandom_range(5, 1));
            default: return lfu_pkg::SET_W'($urandom_range(lfu_pkg::SETS - 1));
        endcase
    endfunction

    // stimulus
    initial
    begin
        int                        order [lfu_pkg::WAYS];
        int                        j;
        int                        tmp;
        int                        r;
        int                        next_drain;
        logic [lfu_pkg::SET_W-1:0] s;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= lfu_pkg::OP_QUERY;
        req_ch.set_index <= '0;
        req_ch.way_index <= '0;
        req_ch.is_write  <= 1'b0;
        req_ch.was_hit   <= 1'b0;
        events_sent = 0;
        idle_pct    = 0;
        quiet       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty sets, first fills, ignored accesses, unused opcode
        put_event(lfu_pkg::OP_QUERY,  6'd0,  4'd0,  1'b0, 1'b0);
        put_event(lfu_pkg::OP_QUERY,  6'd63, 4'd15, 1'b1, 1'b1);
        put_event(lfu_pkg::OP_FILL,   6'd63, 4'd15, 1'b0, 1'b0);
        put_event(lfu_pkg::OP_QUERY,  6'd63, 4'd0,  1'b0, 1'b0);
        put_event(lfu_pkg::OP_FILL,   6'd1,  4'd0,  1'b1, 1'b1);
        put_event(lfu_pkg::OP_FILL,   6'd1,  4'd1,  1'b0, 1'b0);
        put_event(lfu_pkg::OP_QUERY,  6'd1,  4'd9,  1'b0, 1'b0);
        put_event(lfu_pkg::OP_UPDATE, 6'd1,  4'd0,  1'b0, 1'b1);
        put_event(lfu_pkg::OP_UPDATE, 6'd1,  4'd2,  1'b1, 1'b1);
        put_event(lfu_pkg::OP_UPDATE, 6'd1,  4'd3,  1'b0, 1'b0);
        put_event(lfu_pkg::OP_UPDATE, 6'd1,  4'd4,  1'b1, 1'b0);
        put_event(OP_UNUSED,          6'd1,  4'd2,  1'b1, 1'b1);
        put_event(lfu_pkg::OP_QUERY,  6'd1,  4'd0,  1'b1, 1'b0);
        put_event(lfu_pkg::OP_UPDATE, 6'd63, 4'd0,  1'b0, 1'b1);
        put_event(lfu_pkg::OP_QUERY,  6'd63, 4'd0,  1'b0, 1'b1);
        put_event(OP_UNUSED,          6'd0,  4'd0,  1'b0, 1'b0);
        put_event(lfu_pkg::OP_QUERY,  6'd0,  4'd15, 1'b1, 1'b1);
        drain_victims();

        // random: whole-set sequences mixed with noise items
        next_drain = events_sent + DRAIN_EVERY;
        while (events_sent < N_EVENTS)
        begin
            case ($urandom_range(3))
                0, 1:    idle_pct = 0;
                2:       idle_pct = 15;
                default: idle_pct = 50;
            endcase
            if ($urandom_range(99) < 70)
            begin
                s = pick_set();
                // fill every way in shuffled order, now and then not filling at all
                if ($urandom_range(9) < 7)
                begin
                    for (int i = 0; i < lfu_pkg::WAYS; i++)
                        order[i] = i;
                    for (int i = lfu_pkg::WAYS - 1; i > 0; i--)
                    begin
                        j        = $urandom_range(i);
                        tmp      = order[i];
                        order[i] = order[j];
                        order[j] = tmp;
                    end
                    for (int i = 0; i < lfu_pkg::WAYS; i++)
                    begin
                        put_event(lfu_pkg::OP_FILL, s, lfu_pkg::WAY_W'(order[i]),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                        if ($urandom_range(3) == 0)
                            put_event(lfu_pkg::OP_QUERY, s,
                                      lfu_pkg::WAY_W'($urandom_range(lfu_pkg::WAYS - 1)),
                                      1'($urandom_range(1)), 1'($urandom_range(1)));
                    end
                end
                // hits on a few favourite ways so counts pull apart, and queries
                repeat ($urandom_range(30, 8))
                begin
                    r = $urandom_range(99);
                    if (r < 30)
                        put_event(lfu_pkg::OP_QUERY, s,
                                  lfu_pkg::WAY_W'($urandom_range(lfu_pkg::WAYS - 1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                    else if (r < 40)
                        put_event(lfu_pkg::OP_FILL, s,
                                  lfu_pkg::WAY_W'($urandom_range(lfu_pkg::WAYS - 1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                    else
                        put_event(lfu_pkg::OP_UPDATE, s,
                                  lfu_pkg::WAY_W'($urandom_range(1)
                                                  ? $urandom_range(lfu_pkg::WAYS - 1)
                                                  : $urandom_range(3)),
                                  1'($urandom_range(4) == 0), 1'($urandom_range(9) != 0));
                end
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    put_event(lfu_pkg::OP_W'($urandom_range(3)), pick_set(),
                              lfu_pkg::WAY_W'($urandom_range(lfu_pkg::WAYS - 1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            if (events_sent >= next_drain)
            begin
                drain_victims();
                next_drain = events_sent + DRAIN_EVERY;
            end
        end

        // wind down and give the verdict
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (victims_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && victims_due == 0)
            $display("lfu_replacement_lru_tiebreak_core_tb: PASS");
        else
            $display("lfu_replacement_lru_tiebreak_core_tb: FAIL");
        $finish;
    end

    // victim receiver with random stall bursts
    initial
    begin
        int stall;

        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else if (!quiet && idle_pct != 0 && $urandom_range(99) < idle_pct / 3)
            begin
                rsp_ch.ready <= 1'b0;
                stall = $urandom_range(15, 1) - 1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled = 0;
        else
            stalled++;
        if (stalled >= WATCHDOG_LIMIT)
        begin
            $display("lfu_replacement_lru_tiebreak_core_tb: FAIL");
            $finish;
        end
    end

endmodule
